// ----- src/met_pkg.sv -----
// ----------------------------------------------------------------------------
// met_pkg: shared types and constants for the escape-time unit
// fixed-point format, register indexes, sequencer states, saturation helper
// ----------------------------------------------------------------------------
package met_pkg;

  // fixed-point format of coordinates and the iterate
  localparam int FRAC_BITS = 24;
  localparam int COORD_W   = 32;

  // iteration limit and grid clamp
  localparam int MAX_ITERATIONS = 100000;
  localparam int COUNT_W        = 17;
  localparam int MAX_DIM        = 4096;
  localparam int DIM_W          = 13;
  localparam int INDEX_W        = 12;

  // multiplier operands hold a coordinate plus one guard bit
  localparam int MUL_W  = COORD_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  // wide enough for edge + index * step and for the iterate before saturation
  localparam int SUM_W  = 48;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_REAL_LEFT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REAL_RIGHT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAG_LOWER  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAG_UPPER  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 3'd5;

  // reset view: -2.0 .. 2.0 on both axes, 400 x 400 grid
  localparam logic signed [COORD_W-1:0] EDGE_NEG_RESET = -(32'sd2 <<< FRAC_BITS);
  localparam logic signed [COORD_W-1:0] EDGE_POS_RESET = 32'sd2 <<< FRAC_BITS;
  localparam logic [DIM_W-1:0]          GRID_RESET     = 13'd400;

  // constants of the shortcut and escape tests
  localparam logic signed [MUL_W-1:0]  QUARTER_OP   = 33'sd1 <<< (FRAC_BITS - 2);
  localparam logic signed [MUL_W-1:0]  ONE_OP       = 33'sd1 <<< FRAC_BITS;
  localparam logic signed [PROD_W-1:0] CARD_QUARTER = 66'sd1 <<< (FRAC_BITS - 2);
  localparam logic signed [PROD_W-1:0] BULB_LIMIT   = 66'sd1 <<< (2 * FRAC_BITS - 4);
  localparam logic signed [PROD_W-1:0] ESCAPE_LIMIT = 66'sd1 <<< (2 * FRAC_BITS + 2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV,
    ST_MAP_MUL,
    ST_MAP_ADD,
    ST_CARD,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_BULB,
    ST_PSQ,
    ST_SHORT,
    ST_ITER_MUL,
    ST_ITER_UPD
  } state_t;

  // clamp a wide signed value into the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if ((&v[SUM_W-1:COORD_W-1]) || !(|v[SUM_W-1:COORD_W-1])) begin
      r = v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- src/mandelbrot_escape_time_unit.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit: escape-time count for one pixel
// maps a pixel to a point c, tests the main cardioid and the period-2 bulb,
// then iterates z = z^2 + c in Q7.24 until |z|^2 >= 4 or the limit
// ----------------------------------------------------------------------------
//
// channel   signals                                   direction  beat taken when
// -------   ----------------------------------------  ---------  ----------------------
// pixel     start, busy, real_index, imag_index       in         start && !busy
// count     done, iteration_count                     out        every cycle done is high
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in         cfg_valid && cfg_ready
//
// one pixel at a time; busy stays high from the accepted beat until the
// cycle in which done pulses, and a new pixel may be started in that cycle
// set-up: per axis a restoring divider (one quotient bit a cycle) plus a
// multiply and an add, then an integer square root (one result bit a
// cycle) and three passes through the multiplier bank for the cardioid
// and bulb tests
// in each iteration the shared multiplier bank produces zr^2, zi^2 and
// zr*zi into a register, and the next cycle forms the new z and checks
// escape
// reset clears the sequencer and loads the default view; the receiver cannot
// stall, done is a one-cycle strobe; config is taken only while idle
//
module mandelbrot_escape_time_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [met_pkg::INDEX_W-1:0]         real_index,
  input  logic [met_pkg::INDEX_W-1:0]         imag_index,
  output logic                                done,
  output logic [met_pkg::COUNT_W-1:0]         iteration_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [met_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [met_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW = met_pkg::COORD_W;
  localparam int MW = met_pkg::MUL_W;
  localparam int PW = met_pkg::PROD_W;
  localparam int SW = met_pkg::SUM_W;
  localparam int IW = met_pkg::INDEX_W;
  localparam int DW = met_pkg::DIM_W;

  // sequencer
  met_pkg::state_t state, state_next;

  // configuration registers
  logic signed [CW-1:0] real_left, real_right, imag_lower, imag_upper;
  logic [DW-1:0]        grid_width, grid_height;

  // captured pixel and axis select (0 real, 1 imaginary)
  logic [IW-1:0] idx_real, idx_imag;
  logic          coord_sel;

  // divider: quotient shift register, partial remainder, sign, bit counter
  logic [CW-1:0] div_quot;
  logic [IW-1:0] div_rem;
  logic          div_neg;
  logic [4:0]    div_cnt;

  // mapped point
  logic signed [CW-1:0] cr, ci;

  // square root: remainder, result, current bit
  logic [63:0] sq_rem, sq_res, sq_bit;

  logic bulb_in;

  // iterate and its count
  logic signed [CW-1:0]          zr, zi;
  logic [met_pkg::COUNT_W-1:0]   iter_cnt;

  // shared multiplier bank: a*a, b*b and a*b, registered
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_aa, prod_bb, prod_ab;

  // ---------------------------------------------------------------------------
  // axis selection and divider datapath
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] axis_lo, axis_hi;
  logic [DW-1:0]        axis_grid, divisor;
  logic signed [CW:0]   span, span_neg;
  logic [CW-1:0]        span_mag;
  logic [DW:0]          div_trial;
  logic [DW-1:0]        div_shift;
  logic [IW-1:0]        axis_idx;

  assign axis_lo   = coord_sel ? imag_lower : real_left;
  assign axis_hi   = coord_sel ? imag_upper : real_right;
  assign axis_grid = coord_sel ? grid_height : grid_width;
  assign axis_idx  = coord_sel ? idx_imag : idx_real;

  // zero acts as one, anything above the largest grid is clamped
  always_comb begin
    if (axis_grid == '0) begin
      divisor = DW'(1);
    end else if (axis_grid > DW'(met_pkg::MAX_DIM)) begin
      divisor = DW'(met_pkg::MAX_DIM);
    end else begin
      divisor = axis_grid;
    end
  end

  assign span      = $signed({axis_hi[CW-1], axis_hi}) - $signed({axis_lo[CW-1], axis_lo});
  assign span_neg  = -span;
  assign span_mag  = span[CW] ? span_neg[CW-1:0] : span[CW-1:0];
  assign div_shift = {div_rem, div_quot[CW-1]};
  assign div_trial = {1'b0, div_shift} - {1'b0, divisor};

  // edge + index * step, the step sign applied after the unsigned multiply
  logic signed [SW-1:0] map_off, map_sum;
  assign map_off = div_neg ? -prod_ab[SW-1:0] : prod_ab[SW-1:0];
  assign map_sum = $signed({{(SW-CW){axis_lo[CW-1]}}, axis_lo}) + map_off;

  // ---------------------------------------------------------------------------
  // square root step
  // ---------------------------------------------------------------------------
  logic [64:0] sq_trial;
  logic        sq_take;
  assign sq_trial = {1'b0, sq_res} + {1'b0, sq_bit};
  assign sq_take  = {1'b0, sq_rem} >= sq_trial;

  // ---------------------------------------------------------------------------
  // shortcut and escape tests
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] prod_sum, card_rhs, cr_wide;
  logic                 card_in, escaped, iter_last;

  assign prod_sum = prod_aa + prod_bb;
  // p - floor(2 p^2 / 2^frac) + 1/4, with p^2 in prod_aa
  assign card_rhs = $signed({{(PW-CW){1'b0}}, sq_res[CW-1:0]})
                  - (prod_aa >>> (met_pkg::FRAC_BITS - 1)) + met_pkg::CARD_QUARTER;
  assign cr_wide  = $signed({{(PW-CW){cr[CW-1]}}, cr});
  assign card_in  = cr_wide < card_rhs;
  assign escaped  = prod_sum >= met_pkg::ESCAPE_LIMIT;
  assign iter_last = escaped || (iter_cnt == met_pkg::COUNT_W'(met_pkg::MAX_ITERATIONS));

  // ---------------------------------------------------------------------------
  // next iterate from the registered products
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] zr_diff, zr_wide, zi_wide;
  logic signed [SW-1:0] zr_sum, zi_sum;

  assign zr_diff = prod_aa - prod_bb;
  assign zr_wide = zr_diff >>> met_pkg::FRAC_BITS;
  assign zi_wide = prod_ab >>> (met_pkg::FRAC_BITS - 1);
  assign zr_sum  = $signed(zr_wide[SW-1:0]) + $signed({{(SW-CW){cr[CW-1]}}, cr});
  assign zi_sum  = $signed(zi_wide[SW-1:0]) + $signed({{(SW-CW){ci[CW-1]}}, ci});

  // ---------------------------------------------------------------------------
  // multiplier operand select
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      met_pkg::ST_MAP_MUL: begin
        mul_a = $signed({{(MW-IW){1'b0}}, axis_idx});
        mul_b = $signed({1'b0, div_quot});
      end
      met_pkg::ST_CARD: begin
        mul_a = $signed({cr[CW-1], cr}) - met_pkg::QUARTER_OP;
        mul_b = $signed({ci[CW-1], ci});
      end
      met_pkg::ST_BULB: begin
        mul_a = $signed({cr[CW-1], cr}) + met_pkg::ONE_OP;
        mul_b = $signed({ci[CW-1], ci});
      end
      met_pkg::ST_PSQ: begin
        mul_a = $signed({1'b0, sq_res[CW-1:0]});
      end
      met_pkg::ST_ITER_MUL: begin
        mul_a = $signed({zr[CW-1], zr});
        mul_b = $signed({zi[CW-1], zi});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_aa <= mul_a * mul_a;
    prod_bb <= mul_b * mul_b;
    prod_ab <= mul_a * mul_b;
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= met_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state != met_pkg::ST_IDLE);
    cfg_ready  = (state == met_pkg::ST_IDLE);
    case (state)
      met_pkg::ST_IDLE: begin
        if (start) begin
          state_next = met_pkg::ST_DIV_INIT;
        end
      end
      met_pkg::ST_DIV_INIT: state_next = met_pkg::ST_DIV;
      met_pkg::ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = met_pkg::ST_MAP_MUL;
        end
      end
      met_pkg::ST_MAP_MUL: state_next = met_pkg::ST_MAP_ADD;
      met_pkg::ST_MAP_ADD: begin
        state_next = coord_sel ? met_pkg::ST_CARD : met_pkg::ST_DIV_INIT;
      end
      met_pkg::ST_CARD:      state_next = met_pkg::ST_SQRT_INIT;
      met_pkg::ST_SQRT_INIT: state_next = met_pkg::ST_SQRT;
      met_pkg::ST_SQRT: begin
        if (sq_bit[0]) begin
          state_next = met_pkg::ST_BULB;
        end
      end
      met_pkg::ST_BULB: state_next = met_pkg::ST_PSQ;
      met_pkg::ST_PSQ:  state_next = met_pkg::ST_SHORT;
      met_pkg::ST_SHORT: begin
        state_next = (card_in || bulb_in) ? met_pkg::ST_IDLE : met_pkg::ST_ITER_MUL;
      end
      met_pkg::ST_ITER_MUL: state_next = met_pkg::ST_ITER_UPD;
      met_pkg::ST_ITER_UPD: begin
        state_next = iter_last ? met_pkg::ST_IDLE : met_pkg::ST_ITER_MUL;
      end
      default: state_next = met_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        met_pkg::ST_IDLE: begin
          if (start) begin
            idx_real  <= real_index;
            idx_imag  <= imag_index;
            coord_sel <= 1'b0;
          end
        end
        met_pkg::ST_DIV_INIT: begin
          div_quot <= span_mag;
          div_rem  <= '0;
          div_neg  <= span[CW];
          div_cnt  <= '1;
        end
        met_pkg::ST_DIV: begin
          // restoring division, one quotient bit a cycle
          div_quot <= {div_quot[CW-2:0], ~div_trial[DW]};
          if (!div_trial[DW]) begin
            div_rem <= div_trial[IW-1:0];
          end else begin
            div_rem <= div_shift[IW-1:0];
          end
          div_cnt <= div_cnt - 5'd1;
        end
        met_pkg::ST_MAP_ADD: begin
          if (coord_sel) begin
            ci <= met_pkg::sat_coord(map_sum);
          end else begin
            cr <= met_pkg::sat_coord(map_sum);
          end
          coord_sel <= 1'b1;
        end
        met_pkg::ST_SQRT_INIT: begin
          // (x - 1/4)^2 + y^2 sits in the product registers
          sq_rem <= prod_sum[63:0];
          sq_res <= '0;
          sq_bit <= 64'h1 << 62;
        end
        met_pkg::ST_SQRT: begin
          if (sq_take) begin
            sq_rem <= sq_rem - sq_trial[63:0];
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
        met_pkg::ST_PSQ: begin
          // (x + 1)^2 + y^2 sits in the product registers
          bulb_in <= (prod_sum < met_pkg::BULB_LIMIT);
        end
        met_pkg::ST_SHORT: begin
          if (card_in || bulb_in) begin
            done            <= 1'b1;
            iteration_count <= met_pkg::COUNT_W'(met_pkg::MAX_ITERATIONS);
          end else begin
            zr       <= '0;
            zi       <= '0;
            iter_cnt <= '0;
          end
        end
        met_pkg::ST_ITER_UPD: begin
          if (iter_last) begin
            done            <= 1'b1;
            iteration_count <= iter_cnt;
          end else begin
            zr       <= met_pkg::sat_coord(zr_sum);
            zi       <= met_pkg::sat_coord(zi_sum);
            iter_cnt <= iter_cnt + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // configuration registers, unknown indexes are dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      real_left   <= met_pkg::EDGE_NEG_RESET;
      real_right  <= met_pkg::EDGE_POS_RESET;
      imag_lower  <= met_pkg::EDGE_NEG_RESET;
      imag_upper  <= met_pkg::EDGE_POS_RESET;
      grid_width  <= met_pkg::GRID_RESET;
      grid_height <= met_pkg::GRID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        met_pkg::CFG_REAL_LEFT:   real_left   <= cfg_data[CW-1:0];
        met_pkg::CFG_REAL_RIGHT:  real_right  <= cfg_data[CW-1:0];
        met_pkg::CFG_IMAG_LOWER:  imag_lower  <= cfg_data[CW-1:0];
        met_pkg::CFG_IMAG_UPPER:  imag_upper  <= cfg_data[CW-1:0];
        met_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data[DW-1:0];
        met_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_data[DW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for mandelbrot_escape_time_unit
// drives pixel indexes under several views of the complex plane, predicts
// the escape count of every pixel in Q7.24 and checks each count strobe
// ----------------------------------------------------------------------------
//
// plan
//   reset view    default -2..2 view: corners, cardioid, period-2 bulb,
//                 the point -2, pixels far beyond the grid
//   limit         a point in a period-4 bulb that the shortcut misses, so
//                 the loop runs all the way to the iteration limit
//   extreme views edges at the ends of the 32-bit range, reversed edges,
//                 zero divisor, divisor above the clamp, zero step, writes
//                 to register indexes that do not exist
//   random views  random windows near the set with random grid sizes;
//                 pixels whose orbit runs long are skipped to bound the run
//
// the pixel sender works in bursts with random gaps; the count side cannot
// be held off, so every done strobe is compared with the oldest prediction
//
module testbench;

  // end of run and a hard stop in case the block hangs
  localparam int TAIL_CYCLES = 400;
  localparam int RUN_LIMIT_NS = 200_000_000;

  // random pixels with an orbit this long or longer are redrawn, up to 1000 tries
  localparam int unsigned CHEAP_LIMIT = 2000;

  // register indexes with no register behind them
  localparam logic [met_pkg::CFG_INDEX_W-1:0] CFG_NO_REG_LO = 3'd6;
  localparam logic [met_pkg::CFG_INDEX_W-1:0] CFG_NO_REG_HI = 3'd7;

  // fixed-point constants of the escape-time math
  localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_MIN = 64'shFFFF_FFFF_8000_0000;
  localparam longint Q_ONE = 64'sd1 <<< met_pkg::FRAC_BITS;
  localparam longint Q_QUARTER = 64'sd1 <<< (met_pkg::FRAC_BITS - 2);
  localparam longint unsigned BULB_MAG = 64'd1 << (2 * met_pkg::FRAC_BITS - 4);
  localparam longint unsigned ESCAPE_MAG = 64'd4 << (2 * met_pkg::FRAC_BITS);

  // -1.3 sits in the period-4 bulb, outside the cardioid and period-2 bulb
  localparam logic signed [met_pkg::COORD_W-1:0] NEAR_PERIOD4 = -32'sd21810381;
  localparam logic signed [met_pkg::COORD_W-1:0] EDGE_MIN = 32'sh8000_0000;
  localparam logic signed [met_pkg::COORD_W-1:0] EDGE_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic [met_pkg::INDEX_W-1:0] re;
    logic [met_pkg::INDEX_W-1:0] im;
    logic [met_pkg::COUNT_W-1:0] count;
  } pixel_expect_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [met_pkg::INDEX_W-1:0] real_index;
  logic [met_pkg::INDEX_W-1:0] imag_index;
  logic done;
  logic [met_pkg::COUNT_W-1:0] iteration_count;
  logic cfg_valid;
  logic cfg_ready;
  logic [met_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [met_pkg::CFG_DATA_W-1:0] cfg_data;

  // shadow of the view registers as the block should hold them
  logic signed [met_pkg::COORD_W-1:0] view_left;
  logic signed [met_pkg::COORD_W-1:0] view_right;
  logic signed [met_pkg::COORD_W-1:0] view_lower;
  logic signed [met_pkg::COORD_W-1:0] view_upper;
  logic [met_pkg::DIM_W-1:0] grid_cols;
  logic [met_pkg::DIM_W-1:0] grid_rows;

  // predicted counts of accepted pixels, oldest first
  pixel_expect_t pending_counts[$];
  pixel_expect_t oldest;
  int mismatches;
  int burst_left;

  mandelbrot_escape_time_unit i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .real_index(real_index),
    .imag_index(imag_index),
    .done(done),
    .iteration_count(iteration_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp_q24(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic longint unsigned mag_sq(longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    return m * m;
  endfunction

  // integer square root, one result bit per pass
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // main cardioid by the square-root test, then the period-2 bulb
  function automatic bit in_shortcut_region(longint x, longint y);
    longint unsigned q;
    longint unsigned p;
    longint bound;
    q = mag_sq(x - Q_QUARTER) + mag_sq(y);
    p = int_sqrt(q);
    bound = longint'(p) - longint'((p * p) >> (met_pkg::FRAC_BITS - 1)) + Q_QUARTER;
    if (x < bound) return 1'b1;
    return (mag_sq(x + Q_ONE) + mag_sq(y)) < BULB_MAG;
  endfunction

  // pixel index to coordinate: divisor clamped to 1..MAX_DIM, step truncated
  // toward zero, extrapolation past the grid saturates
  function automatic longint map_axis(logic signed [met_pkg::COORD_W-1:0] lo,
                                      logic signed [met_pkg::COORD_W-1:0] hi,
                                      logic [met_pkg::DIM_W-1:0] div,
                                      logic [met_pkg::INDEX_W-1:0] idx);
    longint d;
    longint stride;
    d = longint'(div);
    if (d < 1) d = 1;
    if (d > met_pkg::MAX_DIM) d = met_pkg::MAX_DIM;
    stride = (longint'(hi) - longint'(lo)) / d;
    return clamp_q24(longint'(lo) + longint'(idx) * stride);
  endfunction

  // escape count of one pixel under the current view, iterating at most cap
  // times; a shortcut hit returns the full limit
  function automatic int unsigned escape_count(logic [met_pkg::INDEX_W-1:0] re,
                                               logic [met_pkg::INDEX_W-1:0] im,
                                               int unsigned cap);
    longint cr;
    longint ci;
    longint zr;
    longint zi;
    longint nr;
    longint ni;
    longint unsigned mag;
    int unsigned n;
    cr = map_axis(view_left, view_right, grid_cols, re);
    ci = map_axis(view_lower, view_upper, grid_rows, im);
    if (in_shortcut_region(cr, ci)) return met_pkg::MAX_ITERATIONS;
    zr = 0;
    zi = 0;
    mag = 0;
    n = 0;
    while (n < cap && mag < ESCAPE_MAG) begin
      nr = clamp_q24(((longint'(mag_sq(zr)) - longint'(mag_sq(zi))) >>> met_pkg::FRAC_BITS)
                     + cr);
      ni = clamp_q24(((zr * zi) >>> (met_pkg::FRAC_BITS - 1)) + ci);
      zr = nr;
      zi = ni;
      mag = mag_sq(zr) + mag_sq(zi);
      n++;
    end
    return n;
  endfunction

  // ------------------------------------------------------------ sender side

  function automatic int pick_gap();
    case ($urandom_range(0, 9))
      0: begin
        return $urandom_range(20, 250);
      end
      1, 2: begin
        return $urandom_range(3, 19);
      end
      default: begin
        return $urandom_range(1, 2);
      end
    endcase
  endfunction

  function automatic int pick_burst();
    if ($urandom_range(0, 3) == 0) return $urandom_range(10, 25);
    return $urandom_range(1, 4);
  endfunction

  // one pixel beat; start stays high into the next beat of a burst
  task automatic send_pixel(input logic [met_pkg::INDEX_W-1:0] re,
                            input logic [met_pkg::INDEX_W-1:0] im);
    pixel_expect_t e;
    e.re = re;
    e.im = im;
    e.count = met_pkg::COUNT_W'(escape_count(re, im, met_pkg::MAX_ITERATIONS));
    start <= 1'b1;
    real_index <= re;
    imag_index <= im;
    do @(posedge clk); while (busy);
    pending_counts.push_back(e);
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
      burst_left = pick_burst();
    end
  endtask

  // stop sending and let every predicted count come back
  task automatic wait_quiet();
    start <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
  endtask

  // one register beat; valid stays high into the next write of a sequence
  task automatic write_reg(input logic [met_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [met_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      met_pkg::CFG_REAL_LEFT: begin
        view_left = data;
      end
      met_pkg::CFG_REAL_RIGHT: begin
        view_right = data;
      end
      met_pkg::CFG_IMAG_LOWER: begin
        view_lower = data;
      end
      met_pkg::CFG_IMAG_UPPER: begin
        view_upper = data;
      end
      met_pkg::CFG_GRID_WIDTH: begin
        grid_cols = data[met_pkg::DIM_W-1:0];
      end
      met_pkg::CFG_GRID_HEIGHT: begin
        grid_rows = data[met_pkg::DIM_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic load_view(input logic signed [met_pkg::COORD_W-1:0] left,
                           input logic signed [met_pkg::COORD_W-1:0] right,
                           input logic signed [met_pkg::COORD_W-1:0] lower,
                           input logic signed [met_pkg::COORD_W-1:0] upper,
                           input logic [met_pkg::CFG_DATA_W-1:0] cols_word,
                           input logic [met_pkg::CFG_DATA_W-1:0] rows_word);
    write_reg(met_pkg::CFG_REAL_LEFT, left);
    write_reg(met_pkg::CFG_REAL_RIGHT, right);
    write_reg(met_pkg::CFG_IMAG_LOWER, lower);
    write_reg(met_pkg::CFG_IMAG_UPPER, upper);
    write_reg(met_pkg::CFG_GRID_WIDTH, cols_word);
    write_reg(met_pkg::CFG_GRID_HEIGHT, rows_word);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what,
                                 input logic [met_pkg::COUNT_W-1:0] got,
                                 input logic [met_pkg::COUNT_W-1:0] want);
    $display("[%0t] mismatch: %s: count %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // done is a one-cycle strobe; each one takes the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_counts.size() == 0) begin
        report_mismatch("count beat with no pixel pending", iteration_count, '0);
      end else begin
        oldest = pending_counts.pop_front();
        if (iteration_count !== oldest.count) begin
          report_mismatch($sformatf("pixel (%0d,%0d)", oldest.re, oldest.im),
                          iteration_count, oldest.count);
        end
      end
    end
  end

  // ------------------------------------------------------------------- tests

  // default view, step 4/400 on both axes
  task automatic test_reset_view();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    // origin and a point on the cardioid's upper-left flank
    send_pixel(12'd200, 12'd200);
    send_pixel(12'd150, 12'd250);
    // -1 sits in the period-2 bulb
    send_pixel(12'd100, 12'd200);
    // -2 - 32 lsb i escapes on |z|^2 just above 4
    send_pixel(12'd0, 12'd200);
    send_pixel(12'd300, 12'd300);
    send_pixel(12'd399, 12'd399);
    // alternating bit patterns far beyond the grid
    send_pixel(12'd2730, 12'd1365);
  endtask

  // bounded orbit that the shortcut misses runs the full iteration count
  task automatic test_iteration_limit();
    wait_quiet();
    load_view(NEAR_PERIOD4, met_pkg::EDGE_POS_RESET, '0, met_pkg::EDGE_POS_RESET,
              32'd400, 32'd400);
    send_pixel(12'd0, 12'd0);
  endtask

  task automatic test_extreme_views();
    logic [met_pkg::CFG_DATA_W-1:0] noise;
    wait_quiet();
    noise = $urandom;
    // full-range edges, reversed imaginary axis, divisor zero and above clamp
    write_reg(CFG_NO_REG_LO, $urandom);
    load_view(EDGE_MIN, EDGE_MAX, EDGE_MAX, EDGE_MIN,
              {noise[met_pkg::CFG_DATA_W-1:met_pkg::DIM_W], {met_pkg::DIM_W{1'b0}}},
              {noise[met_pkg::DIM_W-1:0], noise[met_pkg::CFG_DATA_W-1:met_pkg::DIM_W]}
                | 32'h0000_1FFF);
    @(posedge clk);
    write_reg(CFG_NO_REG_HI, $urandom);
    cfg_valid <= 1'b0;
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd2048);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd2048, 12'd2048);
    wait_quiet();
    // steps of zero and of minus one lsb: every pixel lands on the imaginary axis, at most 4095 lsb below the origin
    load_view('0, 32'sd1, '0, -32'sd1, 32'd4096, 32'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2730, 12'd1365);
  endtask

  function automatic logic [met_pkg::CFG_DATA_W-1:0] random_grid_word();
    logic [met_pkg::CFG_DATA_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0: begin
        w[met_pkg::DIM_W-1:0] = '0;
      end
      1: begin
        w[met_pkg::DIM_W-1:0] = met_pkg::DIM_W'($urandom_range(met_pkg::MAX_DIM + 1,
                                                               (1 << met_pkg::DIM_W) - 1));
      end
      2: begin
        w[met_pkg::DIM_W-1:0] = met_pkg::DIM_W'(met_pkg::MAX_DIM);
      end
      3, 4: begin
        w[met_pkg::DIM_W-1:0] = met_pkg::DIM_W'($urandom_range(1, 16));
      end
      default: begin
        w[met_pkg::DIM_W-1:0] = met_pkg::DIM_W'($urandom_range(17, 600));
      end
    endcase
    return w;
  endfunction

  // highest index that stays on the grid for a divisor
  function automatic int unsigned grid_reach(logic [met_pkg::DIM_W-1:0] div);
    if (div == 0) return 1;
    if (div >= met_pkg::MAX_DIM) return met_pkg::MAX_DIM - 1;
    return div;
  endfunction

  // random pixel, mostly on the grid, whose orbit is short or hits the shortcut
  task automatic pick_pixel(output logic [met_pkg::INDEX_W-1:0] re,
                            output logic [met_pkg::INDEX_W-1:0] im);
    int unsigned n;
    for (int tries = 0; tries < 1000; tries++) begin
      re = ($urandom_range(0, 3) == 0) ? met_pkg::INDEX_W'($urandom) :
           met_pkg::INDEX_W'($urandom_range(0, grid_reach(grid_cols)));
      im = ($urandom_range(0, 3) == 0) ? met_pkg::INDEX_W'($urandom) :
           met_pkg::INDEX_W'($urandom_range(0, grid_reach(grid_rows)));
      n = escape_count(re, im, CHEAP_LIMIT);
      if (n < CHEAP_LIMIT || n == met_pkg::MAX_ITERATIONS) break;
    end
  endtask

  task automatic test_random_views();
    logic signed [met_pkg::COORD_W-1:0] left;
    logic signed [met_pkg::COORD_W-1:0] right;
    logic signed [met_pkg::COORD_W-1:0] lower;
    logic signed [met_pkg::COORD_W-1:0] upper;
    logic [met_pkg::INDEX_W-1:0] re;
    logic [met_pkg::INDEX_W-1:0] im;
    for (int phase = 0; phase < 4; phase++) begin
      wait_quiet();
      // real window starts in -2.5..0.5, imaginary in -1.5..1.5
      left = $signed($urandom_range(0, 3 << met_pkg::FRAC_BITS))
             - (5 <<< (met_pkg::FRAC_BITS - 1));
      right = left + $signed($urandom_range(1 << (met_pkg::FRAC_BITS - 3),
                                            3 << met_pkg::FRAC_BITS));
      lower = $signed($urandom_range(0, 3 << met_pkg::FRAC_BITS))
              - (3 <<< (met_pkg::FRAC_BITS - 1));
      upper = lower + $signed($urandom_range(1 << (met_pkg::FRAC_BITS - 3),
                                             2 << met_pkg::FRAC_BITS));
      if ($urandom_range(0, 3) == 0) begin
        load_view(right, left, lower, upper, random_grid_word(), random_grid_word());
      end else if ($urandom_range(0, 2) == 0) begin
        load_view(left, right, upper, lower, random_grid_word(), random_grid_word());
      end else begin
        load_view(left, right, lower, upper, random_grid_word(), random_grid_word());
      end
      for (int k = 0; k < 22; k++) begin
        pick_pixel(re, im);
        send_pixel(re, im);
      end
    end
  endtask

  // --------------------------------------------------------------- sequence

  initial begin
    rst = 1'b1;
    start = 1'b0;
    real_index = '0;
    imag_index = '0;
    cfg_valid = 1'b0;
    cfg_index = met_pkg::CFG_REAL_LEFT;
    cfg_data = '0;
    mismatches = 0;
    burst_left = pick_burst();
    view_left = met_pkg::EDGE_NEG_RESET;
    view_right = met_pkg::EDGE_POS_RESET;
    view_lower = met_pkg::EDGE_NEG_RESET;
    view_upper = met_pkg::EDGE_POS_RESET;
    grid_cols = met_pkg::GRID_RESET;
    grid_rows = met_pkg::GRID_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_view();
    test_iteration_limit();
    test_extreme_views();
    test_random_views();

    // drain, then watch a while for stray count beats
    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("mandelbrot_escape_time_unit verification clean");
    end else begin
      $display("mandelbrot_escape_time_unit verification failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("mandelbrot_escape_time_unit verification failed");
    $finish;
  end

endmodule
